FILE: design/sbm_pkg.sv
package sbm_pkg;

  localparam int unsigned LOAD_ADDR_BITS = 15;
  localparam logic [15:0] CON_OUT_ADDR   = 16'h8000;
  localparam logic [15:0] CON_IN_ADDR    = 16'h8001;

  typedef struct packed {
    logic                      op;
    logic [LOAD_ADDR_BITS-1:0] load_address;
    logic [7:0]                load_data;
    logic [7:0]                console_in;
  } in_req_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        console_used;
    logic        halted;
    logic [15:0] pc_now;
    logic [15:0] pc_before;
  } out_res_t;

  // single port request toward the byte store
  typedef struct packed {
    logic                      re;
    logic                      we;
    logic [LOAD_ADDR_BITS-1:0] addr;
    logic [7:0]                wdata;
  } mem_req_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

endpackage

FILE: design/sbm_mem.sv
module sbm_mem #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic              clk,
  input  sbm_pkg::mem_req_t mreq,
  output logic [7:0]        rd_data_r
);
  import sbm_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.addr[AW-1:0]] <= mreq.wdata;
    end
    if (mreq.re) begin
      rd_data_r <= mem[mreq.addr[AW-1:0]];
    end
  end

endmodule

FILE: design/sbm_alu.sv
module sbm_alu (
  input  logic [15:0] x,
  input  logic [15:0] y,
  input  logic        sub,
  output logic [15:0] sum,
  output logic        carry
);
  import sbm_pkg::*;

  logic [15:0] y_eff;

  // sub: x + ~y + 1, carry clear means borrow
  assign y_eff = sub ? ~y : y;
  assign {carry, sum} = {1'b0, x} + {1'b0, y_eff} + {16'h0000, sub};

endmodule

FILE: design/subleq_byte_machine_step.sv
// One subleq machine request per start pulse. A load request writes one byte into the
// program store, and its result is shown in the cycle right after acceptance. A step
// request fetches six address bytes, reads both operands and writes the difference to
// the b address, all through the single port of the store unless an address is the
// console. Its result is shown in S_DONE, after states S_FETCH, S_RDA and S_RDB. A step
// while halted (pc at or above 0x8000) gives an unchanged result in the cycle right after
// acceptance, like a load. busy stays high until the cycle after the result, so no new
// request is accepted before then. The result is shown for exactly one cycle with
// out_strobe high and cannot be held off, so the receiver must take it then.
module subleq_byte_machine_step #(
  parameter int unsigned MEM_BYTES = 32768
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sbm_pkg::in_req_t  in_req,
  output logic              busy,
  output logic              out_strobe,
  output sbm_pkg::out_res_t out_res
);
  import sbm_pkg::*;

  localparam int unsigned AW        = $clog2(MEM_BYTES);
  localparam logic [16:0] MEM_LIMIT = 17'(MEM_BYTES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_RDA   = 5'b00100,
    S_RDB   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [15:0] ptr_r, ptr_nxt;
  logic [39:0] fb_r, fb_nxt;
  logic [7:0]  va_r, va_nxt;
  logic [7:0]  con_r, con_nxt;
  logic        src_mem_r, src_mem_nxt;
  logic        src_con_r, src_con_nxt;
  logic        used_r, used_nxt;
  logic        wrote_r, wrote_nxt;
  logic [7:0]  wbyte_r, wbyte_nxt;

  mem_req_t    mreq;
  logic [7:0]  mem_rdata;
  logic [7:0]  bus_byte;
  logic        rd_go;
  logic [15:0] rd_addr;
  logic [15:0] alu_x, alu_y, alu_sum;
  logic        alu_sub, alu_carry;
  logic [15:0] b_addr;
  logic [7:0]  diff;

  sbm_mem #(.DEPTH(MEM_BYTES), .AW(AW)) u_mem (
    .clk       (clk),
    .mreq      (mreq),
    .rd_data_r (mem_rdata)
  );

  sbm_alu u_alu (
    .x     (alu_x),
    .y     (alu_y),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // byte returned by the read issued last cycle
  assign bus_byte = src_mem_r ? mem_rdata : (src_con_r ? con_r : 8'h00);
  assign b_addr   = fb_r[31:16];
  assign diff     = alu_sum[7:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pc_nxt    = pc_r;
    prev_nxt  = prev_r;
    ptr_nxt   = ptr_r;
    fb_nxt    = fb_r;
    va_nxt    = va_r;
    con_nxt   = con_r;
    used_nxt  = used_r;
    wrote_nxt = wrote_r;
    wbyte_nxt = wbyte_r;
    mreq      = '0;
    rd_go     = 1'b0;
    rd_addr   = 16'h0000;
    alu_x     = ptr_r;
    alu_y     = 16'h0001;
    alu_sub   = 1'b0;

    case (state_r)
      S_IDLE: begin
        alu_x = pc_r;
        if (start) begin
          con_nxt   = in_req.console_in;
          used_nxt  = 1'b0;
          wrote_nxt = 1'b0;
          wbyte_nxt = 8'h00;
          state_nxt = S_DONE;
          if (in_req.op == OP_LOAD) begin
            if ({2'b00, in_req.load_address} < MEM_LIMIT) begin
              mreq.we    = 1'b1;
              mreq.addr  = in_req.load_address;
              mreq.wdata = in_req.load_data;
            end
          end else if (!pc_r[15]) begin
            prev_nxt  = pc_r;
            rd_go     = 1'b1;
            rd_addr   = pc_r;
            ptr_nxt   = alu_sum;
            cnt_nxt   = 3'd0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        fb_nxt = {fb_r[31:0], bus_byte};
        if (src_con_r) used_nxt = 1'b1;
        rd_go = 1'b1;
        if (cnt_r == 3'd5) begin
          // operand a address is complete before the last fetch byte lands
          rd_addr   = fb_r[39:24];
          state_nxt = S_RDA;
        end else begin
          rd_addr = ptr_r;
          ptr_nxt = alu_sum;
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_RDA: begin
        va_nxt = bus_byte;
        if (src_con_r) used_nxt = 1'b1;
        rd_go     = 1'b1;
        rd_addr   = b_addr;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        if (src_con_r) used_nxt = 1'b1;
        alu_x   = {8'h00, bus_byte};
        alu_y   = {8'h00, va_r};
        alu_sub = 1'b1;
        if ({1'b0, b_addr} < MEM_LIMIT) begin
          mreq.we    = 1'b1;
          mreq.addr  = b_addr[LOAD_ADDR_BITS-1:0];
          mreq.wdata = diff;
        end else if (b_addr == CON_OUT_ADDR) begin
          wrote_nxt = 1'b1;
          wbyte_nxt = diff;
        end
        // a >= b when b - a borrows or is zero
        pc_nxt    = (!alu_carry || diff == 8'h00) ? fb_r[15:0] : ptr_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    src_mem_nxt = rd_go && ({1'b0, rd_addr} < MEM_LIMIT);
    src_con_nxt = rd_go && (rd_addr == CON_IN_ADDR);
    if (src_mem_nxt) begin
      mreq.re   = 1'b1;
      mreq.addr = rd_addr[LOAD_ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= 3'd0;
      pc_r      <= 16'h0000;
      prev_r    <= 16'h0000;
      src_mem_r <= 1'b0;
      src_con_r <= 1'b0;
      used_r    <= 1'b0;
      wrote_r   <= 1'b0;
      wbyte_r   <= 8'h00;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pc_r      <= pc_nxt;
      prev_r    <= prev_nxt;
      src_mem_r <= src_mem_nxt;
      src_con_r <= src_con_nxt;
      used_r    <= used_nxt;
      wrote_r   <= wrote_nxt;
      wbyte_r   <= wbyte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    fb_r  <= fb_nxt;
    va_r  <= va_nxt;
    con_r <= con_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

  always_comb begin
    out_res.out_valid    = wrote_r;
    out_res.out_byte     = wbyte_r;
    out_res.console_used = used_r;
    out_res.halted       = pc_r[15];
    out_res.pc_now       = pc_r;
    out_res.pc_before    = prev_r;
  end

endmodule

FILE: design/sbm_checker.sv
module sbm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input sbm_pkg::out_res_t out_res
);
  import sbm_pkg::*;

  // a result closes the request and frees the block next cycle
  a_strobe_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy)
    else $error("busy still high after result");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result shown while idle");

  a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_res.halted == out_res.pc_now[15]))
    else $error("halted disagrees with pc");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_res.out_valid) |-> (out_res.out_byte == 8'h00))
    else $error("console byte without write");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy in cycle after request");

endmodule

bind subleq_byte_machine_step sbm_checker u_sbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
